// ===== rtl/poa_pkg.sv =====
package poa_pkg;

  localparam int TableDepth = 64;

  localparam int AddrW   = 32;
  localparam int GuessW  = 64;
  localparam int TimeW   = 63;
  localparam int AvgW    = 40;
  localparam int LimitW  = 20;
  localparam int DiffW   = 32;
  localparam int FracW   = 8;

  // 4*avg + diff*256 needs one bit more than 4*avg, magnitude fits 42 bits
  localparam int NumW    = AvgW + 3;
  localparam int MagW    = NumW - 1;

  // divide by five as a multiply by ceil(2^64 / 5) = 0x3333_3333_3333_3334,
  // exact for dividends below 2^62; the product keeps 64 fraction bits
  localparam int RecipShift = 64;
  localparam int ProdW      = MagW + RecipShift;
  localparam int DivSteps   = 6;
  localparam int DivCntW    = $clog2(DivSteps);

  localparam logic [LimitW-1:0] LimitReset = LimitW'(10000);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [AvgW-1:0]  avg_t;

endpackage

// ===== rtl/poa_ram.sv =====
module poa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/per_client_offset_averager.sv =====
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   client_addr, guessed_time_us, receive_time_us
// out      source     out_valid_o / out_stall_i reply_time_us, average_offset, new_client,
//                                               table_full
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_data_i -> offset_limit
//
// The time from one accept to the next grows with N = entries in use, set by the
// serial key search (one RAM read a cycle) and the divide by five as six shift-add
// steps of a multiply by its reciprocal.
// Items forced to the limit or hitting a full table skip the arithmetic.
// Reset clears the entry count and restores the limit register to its default;
// table RAMs are not cleared.
// A stalled result holds in the output register; the next item is taken meanwhile and
// waits at the end of its work until the register frees.
module per_client_offset_averager #(
  parameter int TABLE_DEPTH = poa_pkg::TableDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [poa_pkg::AddrW-1:0]     client_addr_i,
  input  logic signed [poa_pkg::GuessW-1:0] guessed_time_us_i,
  input  logic [poa_pkg::TimeW-1:0]     receive_time_us_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [poa_pkg::TimeW-1:0]     reply_time_us_o,
  output logic signed [poa_pkg::AvgW-1:0] average_offset_o,
  output logic                          new_client_o,
  output logic                          table_full_o,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [poa_pkg::LimitW-1:0]    cfg_data_i
);

  localparam int IdxW = $clog2(TABLE_DEPTH + 1);
  localparam int AW   = $clog2(TABLE_DEPTH);

  localparam int AvgW       = poa_pkg::AvgW;
  localparam int NumW       = poa_pkg::NumW;
  localparam int MagW       = poa_pkg::MagW;
  localparam int DiffW      = poa_pkg::DiffW;
  localparam int TimeW      = poa_pkg::TimeW;
  localparam int ProdW      = poa_pkg::ProdW;
  localparam int RecipShift = poa_pkg::RecipShift;
  localparam int SubW       = poa_pkg::GuessW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SEARCH,
    ST_PREP,
    ST_MAG,
    ST_DIV,
    ST_NEG,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [poa_pkg::LimitW-1:0]  limit_q, limit_d;
  logic [IdxW-1:0]             used_q, used_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [AW-1:0]               cmp_idx_q, cmp_idx_d;
  logic                        cmp_v_q, cmp_v_d;
  logic [AW-1:0]               slot_q, slot_d;
  logic                        found_q, found_d;
  logic                        added_q, added_d;
  logic                        full_q, full_d;
  poa_pkg::addr_t              key_q, key_d;
  logic signed [poa_pkg::GuessW-1:0] guess_q, guess_d;
  logic [TimeW-1:0]            recv_q, recv_d;
  logic signed [DiffW-1:0]     diff_q, diff_d;
  poa_pkg::avg_t               a_q, a_d;
  logic signed [NumW-1:0]      num_q, num_d;
  logic [MagW-1:0]             mag_q, mag_d;
  logic [ProdW-1:0]            acc_q, acc_d;
  logic [poa_pkg::DivCntW-1:0] cnt_q, cnt_d;
  poa_pkg::avg_t               avg_q, avg_d;

  logic                        out_valid_q, out_valid_d;
  logic [TimeW-1:0]            reply_q, reply_d;
  poa_pkg::avg_t               out_avg_q, out_avg_d;
  logic                        new_q, new_d;
  logic                        tfull_q, tfull_d;

  logic                        key_we, avg_we;
  poa_pkg::addr_t              key_rdata;
  poa_pkg::avg_t               avg_rdata;

  logic signed [SubW-1:0]      sub;
  logic                        pos_ovf, neg_ovf;
  logic [NumW-1:0]             abs_num;
  logic [ProdW-1:0]            addend;
  logic                        below_limit;
  logic                        out_free;

  poa_ram #(.WIDTH(poa_pkg::AddrW), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (used_q[AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (key_rdata)
  );

  poa_ram #(.WIDTH(AvgW), .DEPTH(TABLE_DEPTH)) u_avg_ram (
    .clk_i   (clk_i),
    .we_i    (avg_we),
    .waddr_i (slot_q),
    .wdata_i (avg_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (avg_rdata)
  );

  assign sub     = $signed({2'b00, recv_q}) - $signed({guess_q[SubW-2], guess_q});
  assign pos_ovf = !sub[SubW-1] && (|sub[SubW-2:DiffW-1]);
  assign neg_ovf = sub[SubW-1] && !(&sub[SubW-2:DiffW-1]);
  assign abs_num = num_q[NumW-1] ? (~num_q + NumW'(1)) : num_q;
  assign below_limit = $signed({diff_q[DiffW-1], diff_q})
                     < $signed({(DiffW + 1 - poa_pkg::LimitW)'(0), limit_q});
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // 0x3333_3333_3333_3333 is 3 * (1 + 2^4) * (1 + 2^8) * (1 + 2^16) * (1 + 2^32); add x last
  always_comb begin
    case (cnt_q)
      poa_pkg::DivCntW'(0): addend = acc_q << 1;
      poa_pkg::DivCntW'(1): addend = acc_q << 4;
      poa_pkg::DivCntW'(2): addend = acc_q << 8;
      poa_pkg::DivCntW'(3): addend = acc_q << 16;
      poa_pkg::DivCntW'(4): addend = acc_q << 32;
      default:              addend = ProdW'(mag_q);
    endcase
  end

  always_comb begin
    state_d     = state_q;
    limit_d     = limit_q;
    used_d      = used_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_v_d     = cmp_v_q;
    slot_d      = slot_q;
    found_d     = found_q;
    added_d     = added_q;
    full_d      = full_q;
    key_d       = key_q;
    guess_d     = guess_q;
    recv_d      = recv_q;
    diff_d      = diff_q;
    a_d         = a_q;
    num_d       = num_q;
    mag_d       = mag_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q && out_stall_i;
    reply_d     = reply_q;
    out_avg_d   = out_avg_q;
    new_d       = new_q;
    tfull_d     = tfull_q;
    key_we      = 1'b0;
    avg_we      = 1'b0;

    if (cfg_valid_i) begin
      limit_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = client_addr_i;
          guess_d = guessed_time_us_i;
          recv_d  = receive_time_us_i;
          idx_d   = '0;
          cmp_v_d = 1'b0;
          found_d = 1'b0;
          added_d = 1'b0;
          full_d  = 1'b0;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (pos_ovf) begin
          diff_d = {1'b0, {(DiffW-1){1'b1}}};
        end else if (neg_ovf) begin
          diff_d = {1'b1, {(DiffW-1){1'b0}}};
        end else begin
          diff_d = sub[DiffW-1:0];
        end
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        // read one entry a cycle, compare the one read in the last cycle
        if (cmp_v_q && (key_rdata == key_q)) begin
          slot_d  = cmp_idx_q;
          a_d     = avg_rdata;
          found_d = 1'b1;
        end else if (idx_q == used_q) begin
          if (cmp_v_q) begin
            cmp_v_d = 1'b0;
          end else if (used_q == IdxW'(TABLE_DEPTH)) begin
            full_d = 1'b1;
          end else begin
            key_we  = 1'b1;
            slot_d  = used_q[AW-1:0];
            used_d  = used_q + IdxW'(1);
            a_d     = '0;
            found_d = 1'b1;
            added_d = 1'b1;
          end
        end else begin
          cmp_idx_d = idx_q[AW-1:0];
          cmp_v_d   = 1'b1;
          idx_d     = idx_q + IdxW'(1);
        end

        if (full_d) begin
          avg_d   = '0;
          state_d = ST_FINISH;
        end else if (found_d) begin
          if (below_limit) begin
            state_d = ST_PREP;
          end else begin
            avg_d   = AvgW'({limit_q, poa_pkg::FracW'(0)});
            state_d = ST_FINISH;
          end
        end
      end
      ST_PREP: begin
        num_d = $signed({a_q[AvgW-1], a_q, 2'b00})
              + $signed({{(NumW - DiffW - poa_pkg::FracW){diff_q[DiffW-1]}},
                         diff_q, poa_pkg::FracW'(0)});
        state_d = ST_MAG;
      end
      ST_MAG: begin
        // add half the divisor so the truncating divide rounds to nearest
        mag_d   = abs_num[MagW-1:0] + MagW'(2);
        acc_d   = ProdW'(mag_d);
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // one shift-add a cycle builds mag * ceil(2^64 / 5)
        acc_d = acc_q + addend;
        cnt_d = cnt_q + poa_pkg::DivCntW'(1);
        if (cnt_q == poa_pkg::DivCntW'(poa_pkg::DivSteps - 1)) begin
          state_d = ST_NEG;
        end
      end
      ST_NEG: begin
        avg_d   = num_q[NumW-1] ? (~acc_q[RecipShift +: AvgW] + AvgW'(1))
                                : acc_q[RecipShift +: AvgW];
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register frees
        if (out_free) begin
          avg_we      = found_q;
          out_valid_d = 1'b1;
          reply_d     = recv_q;
          out_avg_d   = avg_q;
          new_d       = added_q;
          tfull_d     = full_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= poa_pkg::LimitReset;
      used_q      <= '0;
      idx_q       <= '0;
      cmp_v_q     <= 1'b0;
      found_q     <= 1'b0;
      added_q     <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      cmp_v_q     <= cmp_v_d;
      found_q     <= found_d;
      added_q     <= added_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    key_q     <= key_d;
    guess_q   <= guess_d;
    recv_q    <= recv_d;
    diff_q    <= diff_d;
    a_q       <= a_d;
    num_q     <= num_d;
    mag_q     <= mag_d;
    acc_q     <= acc_d;
    cnt_q     <= cnt_d;
    avg_q     <= avg_d;
    reply_q   <= reply_d;
    out_avg_q <= out_avg_d;
    new_q     <= new_d;
    tfull_q   <= tfull_d;
  end

  assign out_valid_o      = out_valid_q;
  assign reply_time_us_o  = reply_q;
  assign average_offset_o = out_avg_q;
  assign new_client_o     = new_q;
  assign table_full_o     = tfull_q;

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> average_offset_o == '0 && !new_client_o)
    else $error("table full result carries an average or a new client");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= IdxW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside the finish step");

  a_new_grows_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH && key_we |=> used_q == $past(used_q) + IdxW'(1))
    else $error("appended entry did not advance the entry count");

endmodule

// ===== tb/sv/per_client_offset_averager_tb.sv =====
module per_client_offset_averager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AddrW      = poa_pkg::AddrW;
  localparam int GuessW     = poa_pkg::GuessW;
  localparam int TimeW      = poa_pkg::TimeW;
  localparam int AvgW       = poa_pkg::AvgW;
  localparam int LimitW     = poa_pkg::LimitW;
  localparam int TableDepth = poa_pkg::TableDepth;
  localparam logic [LimitW-1:0] LimitReset = poa_pkg::LimitReset;

  typedef poa_pkg::addr_t addr_t;

  localparam int SettleCycles = 150;   // covers the worst item, a search of every entry
  localparam int HoldCycles   = 3000;
  localparam int DirRows      = 19;
  localparam int MaxReports   = 40;

  localparam logic [TimeW-1:0]         TimeMax  = {TimeW{1'b1}};
  localparam logic signed [GuessW-1:0] GuessMin = {1'b1, {(GuessW-1){1'b0}}};
  localparam logic signed [GuessW-1:0] GuessMax = {1'b0, {(GuessW-1){1'b1}}};
  localparam logic signed [AvgW-1:0]   ForcedReset = AvgW'(10000 * 256);

  typedef struct {
    addr_t                     addr;
    logic signed [GuessW-1:0]  guess;
    logic [TimeW-1:0]          recv;
  } ping_t;

  typedef struct {
    logic [TimeW-1:0]        reply;
    logic signed [AvgW-1:0]  avg;
    logic                    fresh;
    logic                    full;
  } sync_reply_t;

  typedef struct {
    addr_t                     addr;
    logic signed [GuessW-1:0]  guess;
    logic [TimeW-1:0]          recv;
    bit                        typed;
    logic signed [AvgW-1:0]    avg;
    logic                      fresh;
    logic                      full;
  } ping_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [AddrW-1:0]         client_addr_i;
  logic signed [GuessW-1:0] guessed_time_us_i;
  logic [TimeW-1:0]         receive_time_us_i;

  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [TimeW-1:0]         reply_time_us_o;
  logic signed [AvgW-1:0]   average_offset_o;
  logic                     new_client_o;
  logic                     table_full_o;

  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [LimitW-1:0]        cfg_data_i;

  // shadow of the client table and the limit register
  addr_t                   known_addr [TableDepth];
  logic signed [AvgW-1:0]  known_avg  [TableDepth];
  int                      known_count;
  logic [LimitW-1:0]       limit_us;

  sync_reply_t pending_replies[$];
  int          mismatches;
  bit          hold_req;
  int          gapless_left;

  always #5 clk_i = ~clk_i;

  per_client_offset_averager #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .client_addr_i    (client_addr_i),
    .guessed_time_us_i(guessed_time_us_i),
    .receive_time_us_i(receive_time_us_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reply_time_us_o  (reply_time_us_o),
    .average_offset_o (average_offset_o),
    .new_client_o     (new_client_o),
    .table_full_o     (table_full_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // Look up or append the client, then blend the clamped offset into its average, or force it to the limit.
  function automatic sync_reply_t predict_reply(ping_t p);
    logic signed [65:0]   wide;
    logic signed [31:0]   diff;
    logic signed [47:0]   a48;
    logic signed [47:0]   d48;
    logic signed [47:0]   num;
    logic signed [AvgW-1:0] avg;
    int                   slot;
    bit                   hit;
    sync_reply_t          r;
    wide = $signed({3'b000, p.recv}) - $signed({{2{p.guess[GuessW-1]}}, p.guess});
    if (wide > 66'sd2147483647) diff = 32'sh7FFF_FFFF;
    else if (wide < -66'sd2147483648) diff = 32'sh8000_0000;
    else diff = wide[31:0];
    r.reply = p.recv;
    r.avg   = '0;
    r.fresh = 1'b0;
    r.full  = 1'b0;
    hit  = 1'b0;
    slot = 0;
    for (int i = 0; i < known_count; i++) begin
      if (!hit && known_addr[i] == p.addr) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (!hit) begin
      if (known_count < TableDepth) begin
        slot = known_count;
        known_addr[slot] = p.addr;
        known_avg[slot]  = '0;
        known_count++;
        hit     = 1'b1;
        r.fresh = 1'b1;
      end else begin
        r.full = 1'b1;
      end
    end
    if (hit) begin
      if (diff < $signed({12'b0, limit_us})) begin
        a48 = 48'(known_avg[slot]);
        d48 = 48'(diff);
        num = (a48 <<< 2) + (d48 <<< 8);
        // round to nearest, symmetric about zero
        if (num >= 0) avg = AvgW'((num + 2) / 5);
        else avg = AvgW'(-((-num + 2) / 5));
      end else begin
        avg = AvgW'({limit_us, 8'h00});
      end
      known_avg[slot] = avg;
      r.avg = avg;
    end
    return r;
  endfunction

  function automatic ping_t random_ping();
    ping_t  p;
    longint d;
    longint span;
    int     r;
    bit     fresh;
    if (known_count < TableDepth) fresh = ($urandom_range(0, 99) < 12);
    else fresh = ($urandom_range(0, 99) < 8);
    if (fresh || known_count == 0) p.addr = $urandom;
    else p.addr = known_addr[$urandom_range(0, known_count - 1)];
    p.recv = TimeW'({$urandom, $urandom} >> 2);
    span = longint'(limit_us) + 64;
    d = 0;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: d = longint'($urandom_range(0, int'(2 * span))) - span;
      3, 4: d = longint'(limit_us) + longint'($urandom_range(0, 3)) - 2;
      5: d = longint'($urandom_range(0, 200)) - 100;
      6: begin
        if ($urandom_range(0, 1)) d = 64'sd2147483647 + longint'($urandom_range(0, 2)) - 1;
        else d = -64'sd2147483648 + longint'($urandom_range(0, 2)) - 1;
      end
      7: d = longint'($signed($urandom));
      default: ;
    endcase
    if (r >= 8) begin
      // raw times: clamping on both sides and every bit of both fields
      p.recv  = TimeW'({$urandom, $urandom});
      p.guess = {$urandom, $urandom};
      if (r == 9) p.recv = TimeW'($urandom_range(0, 1000));
    end else begin
      p.guess = $signed({1'b0, p.recv}) - d;
    end
    return p;
  endfunction

  function automatic int next_gap();
    int r;
    if (gapless_left > 0) begin
      gapless_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      gapless_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 200);
  endfunction

  // Entered and left at a falling edge; valid stays high when no gap follows.
  task automatic send_ping(input ping_t p, input bit typed, input sync_reply_t want);
    sync_reply_t got;
    int          gap;
    in_valid_i        <= 1'b1;
    client_addr_i     <= p.addr;
    guessed_time_us_i <= p.guess;
    receive_time_us_i <= p.recv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = predict_reply(p);
    pending_replies.push_back(typed ? want : got);
    @(negedge clk_i);
    gap = next_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    drain_replies();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    limit_us = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_pings(input int count, input int hold_at, input int pause_at);
    sync_reply_t none;
    none = '{default: '0};
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      if (n == pause_at) drain_replies();
      send_ping(random_ping(), 1'b0, none);
    end
  endtask

  task automatic check_field(input string what, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    sync_reply_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t ns: unexpected item, expected none got reply_time_us %0d",
                   $time, reply_time_us_o);
      end else begin
        want = pending_replies.pop_front();
        check_field("reply_time_us", 64'(want.reply), 64'(reply_time_us_o));
        check_field("average_offset", 64'(want.avg), 64'(average_offset_o));
        check_field("new_client", 64'(want.fresh), 64'(new_client_o));
        check_field("table_full", 64'(want.full), 64'(table_full_o));
      end
    end
  end

  // Output side: free runs, short stalls, the odd long stall, one long hold on request.
  initial begin
    bit stall;
    int len;
    int r;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 1'b1;
        len = HoldCycles;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          stall = 1'b0;
          len = $urandom_range(1, 200);
        end else if (r < 75) begin
          stall = 1'b0;
          len = $urandom_range(1, 4);
        end else if (r < 93) begin
          stall = 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          stall = 1'b1;
          len = $urandom_range(20, 250);
        end
      end
      @(negedge clk_i);
      out_stall_i <= stall;
      repeat (len - 1) @(negedge clk_i);
    end
  end

  initial begin
    #50_000_000;
    $display("per_client_offset_averager_tb failed");
    $finish;
  end

  initial begin
    ping_row_t   rows [DirRows];
    ping_t       p;
    sync_reply_t want;

    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    client_addr_i     = '0;
    guessed_time_us_i = '0;
    receive_time_us_i = '0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    mismatches        = 0;
    hold_req          = 1'b0;
    gapless_left      = 0;
    known_count       = 0;
    limit_us          = LimitReset;

    // addr, guess, recv, typed, avg, new_client, table_full (limit at reset value)
    rows[0]  = '{32'h0, 64'sd0, 63'd0, 1'b1, 40'sd0, 1'b1, 1'b0};
    rows[1]  = '{32'hFFFF_FFFF, 64'sd0, TimeMax, 1'b1, ForcedReset, 1'b1, 1'b0};
    rows[2]  = '{32'hFFFF_FFFF, GuessMin, TimeMax, 1'b1, ForcedReset, 1'b0, 1'b0};
    rows[3]  = '{32'h0, GuessMax, 63'd0, 1'b0, '0, 1'b0, 1'b0};
    rows[4]  = '{32'h0, GuessMin, 63'd0, 1'b1, ForcedReset, 1'b0, 1'b0};
    rows[5]  = '{32'h0, 64'sd0, 63'd9999, 1'b0, '0, 1'b0, 1'b0};
    rows[6]  = '{32'h0, 64'sd0, 63'd10000, 1'b1, ForcedReset, 1'b0, 1'b0};
    rows[7]  = '{32'h0, 64'sd1, 63'd0, 1'b0, '0, 1'b0, 1'b0};
    rows[8]  = '{32'h1, 64'sh0000_0000_8000_0000, 63'd0, 1'b0, '0, 1'b0, 1'b0};
    rows[9]  = '{32'h1, 64'shFFFF_FFFF_8000_0000, 63'd0, 1'b1, ForcedReset, 1'b0, 1'b0};
    rows[10] = '{32'h2, -64'sd1, 63'd9998, 1'b0, '0, 1'b0, 1'b0};
    rows[11] = '{32'h8000_0000, 64'sh5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
                 1'b0, '0, 1'b0, 1'b0};
    rows[12] = '{32'h5555_5555, 64'shAAAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
                 1'b1, ForcedReset, 1'b1, 1'b0};
    rows[13] = '{32'hAAAA_AAAA, 64'sd5000, 63'd5000, 1'b1, 40'sd0, 1'b1, 1'b0};
    rows[14] = '{32'hAAAA_AAAA, 64'sd0, 63'd12345, 1'b1, ForcedReset, 1'b0, 1'b0};
    rows[15] = '{32'hAAAA_AAAA, 64'sd0, 63'd2, 1'b0, '0, 1'b0, 1'b0};
    rows[16] = '{32'h3, 64'sd300, 63'd100, 1'b1, -40'sd10240, 1'b1, 1'b0};
    rows[17] = '{32'h3, 64'sd300, 63'd100, 1'b0, '0, 1'b0, 1'b0};
    rows[18] = '{32'h3, 64'sd1, 63'd0, 1'b0, '0, 1'b0, 1'b0};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      p    = '{rows[i].addr, rows[i].guess, rows[i].recv};
      want = '{rows[i].recv, rows[i].avg, rows[i].fresh, rows[i].full};
      send_ping(p, rows[i].typed, want);
    end

    random_pings(300, -1, -1);
    write_limit('0);
    random_pings(225, -1, -1);
    write_limit({LimitW{1'b1}});
    random_pings(225, 40, -1);   // long output hold: the block must back up its input
    write_limit(LimitW'($urandom_range(1, 1000)));
    random_pings(225, -1, 120);  // sender waits out every open reply midway
    write_limit(LimitW'(1));
    random_pings(225, -1, -1);
    write_limit(LimitW'($urandom_range(0, (1 << LimitW) - 1)));
    random_pings(225, -1, -1);
    write_limit(LimitReset);
    random_pings(225, -1, -1);

    drain_replies();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("per_client_offset_averager_tb passed");
    end else begin
      $display("per_client_offset_averager_tb failed");
    end
    $finish;
  end

endmodule
